FILE: hdl/bmf_pkg.sv
// Shared constants, result record type and pixel decision function for the majority filter.
package bmf_pkg;

   // Image geometry limits.
   localparam int MAX_COLS   = 2048;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = 16;
   localparam int CFG_COLS_W = 12;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Row store entry: bit 1 holds the row two above, bit 0 the row just above.
   localparam int STORE_W = 2;

   // Result queue sizing; one input beat can give up to three result beats.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int MAX_BURST   = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [ROW_W-1:0]      RESET_ROWS = 16'd480;
   localparam logic [CFG_COLS_W-1:0] RESET_COLS = 12'd640;

   // One filtered pixel with its coordinates.
   typedef struct packed {
      logic             filtered_pixel;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             end_of_image;
   } result_type;

   // A white pixel with more than two black neighbors turns black, and a black pixel
   // with more than two white neighbors turns white.
   function automatic logic decide_pixel(input logic center, input logic [2:0] present,
                                         input logic [2:0] whites);
      logic [2:0] blacks;
      logic       result;
      blacks = present - whites;
      result = center;
      if (center && (blacks > 3'd2)) begin
         result = 1'b0;
      end else if (!center && (whites > 3'd2)) begin
         result = 1'b1;
      end
      return result;
   endfunction

endpackage

FILE: hdl/bmf_ram.sv
// Generic synchronous RAM with one write port and two registered read ports (read-first).
module bmf_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Reads return the contents from before a write to the same address in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: hdl/bmf_queue.sv
// Result queue that takes up to three beats per cycle and delivers one per cycle.
module bmf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_count,
   input  bmf_pkg::result_type [2:0]     push_beats,
   input  logic                          pop,
   output bmf_pkg::result_type           head_beat,
   output logic [bmf_pkg::QUEUE_AW:0]    level
);
   import bmf_pkg::*;

   result_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   level_ff, level_in;
   logic [QUEUE_AW-1:0] slot_addr [MAX_BURST];

   // Slots that the incoming beats land in.
   always_comb begin
      for (int k = 0; k < MAX_BURST; k++) begin
         slot_addr[k] = wr_ptr_ff + QUEUE_AW'(k);
      end
   end

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      level_in  = level_ff + (QUEUE_AW+1)'(push_count) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Beat storage.
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BURST; k++) begin
         if (2'(k) < push_count) begin
            entry_ff[slot_addr[k]] <= push_beats[k];
         end
      end
   end

   assign head_beat = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

FILE: hdl/binary_majority_filter_4n.sv
// Top level of the four-neighbor binary majority filter.
// A one-bit image enters in raster order, one pixel per beat, and each pixel leaves
// filtered by the majority of its up, down, left and right neighbors from the original
// image, tagged with its row and column; the bottom-right pixel carries end_of_image.
// Pixel (r,c) is delivered once pixel (r+1,c) has come in, and on the last row each
// pixel also releases its left neighbor (and, in the last column, itself). Two rows of
// history sit in one 2048 x 2-bit RAM that is read at columns c and c+1 and written back
// at column c, with forwarding of the previous write. With an empty result queue, the
// first result of a beat passes through the work stage register and then the result
// queue before rsp_valid shows it. Rows above the last take one pixel per cycle while
// the output does not stall; on the last row the one-result-per-cycle output sets
// the pace, with an eight-beat result queue absorbing the bursts. The user must write
// image_rows and image_cols only between images or while the block is idle; the block does not enforce it.
module binary_majority_filter_4n (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_filtered_pixel,
   output logic [bmf_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [bmf_pkg::COL_W-1:0]         rsp_out_col,
   output logic                              rsp_end_of_image,
   input  logic                              csr_wr_en,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import bmf_pkg::*;

   // Configuration registers.
   logic [ROW_W-1:0]      image_rows_ff, image_rows_in;
   logic [CFG_COLS_W-1:0] image_cols_ff, image_cols_in;

   // Position of the next input pixel and the two pixels before it in the row.
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [1:0]       window_ff, window_in;

   // Work stage: the accepted pixel meets the row store data.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pix_ff, s1_pix_in;
   logic [ROW_W-1:0] s1_row_ff, s1_row_in;
   logic [COL_W-1:0] s1_col_ff, s1_col_in;
   logic             s1_last_row_ff, s1_last_row_in;
   logic             s1_last_col_ff, s1_last_col_in;
   logic [1:0]       s1_win_ff, s1_win_in;

   // Row above at the previous column, and the last store write for forwarding.
   logic               prev_center_ff, prev_center_in;
   logic               wr_valid_ff, wr_valid_in;
   logic [COL_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [STORE_W-1:0] wr_data_ff, wr_data_in;

   logic               accept;
   logic [COL_W-1:0]   last_col_idx;
   logic [ROW_W-1:0]   last_row_idx;
   logic               at_last_row;
   logic               at_last_col;
   logic [COL_W-1:0]   next_col;
   logic [STORE_W-1:0] rd_data_a, rd_data_b;
   logic [STORE_W-1:0] entry_c, entry_r;
   logic [COL_W-1:0]   s1_col_right;
   logic               has_up, has_up2, has_left, has_left2, has_right;
   logic               above_c, above2_c, above_r;
   logic               r1_en, r2_en, r3_en;
   logic [2:0]         present1, whites1, present2, whites2, present3, whites3;
   result_type         res1, res2, res3;
   result_type [2:0]   push_beats;
   logic [1:0]         push_count;
   logic               pop;
   result_type         head_beat;
   logic [QUEUE_AW:0]  q_level;

   assign accept = req_valid && !req_stall;

   // Configuration writes.
   always_comb begin
      image_rows_in = image_rows_ff;
      image_cols_in = image_cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_ROWS: image_rows_in = csr_wr_data[ROW_W-1:0];
            REG_IMAGE_COLS: image_cols_in = csr_wr_data[CFG_COLS_W-1:0];
            default: ;
         endcase
      end
   end

   // Last row and column, with zero counting as one and columns capped at the store size.
   always_comb begin
      if (image_cols_ff == '0) begin
         last_col_idx = '0;
      end else if (image_cols_ff > CFG_COLS_W'(MAX_COLS)) begin
         last_col_idx = COL_W'(MAX_COLS - 1);
      end else begin
         last_col_idx = COL_W'(image_cols_ff - 1'b1);
      end
      last_row_idx = (image_rows_ff == '0) ? '0 : image_rows_ff - 1'b1;
      at_last_row  = row_count_ff >= last_row_idx;
      at_last_col  = col_count_ff >= last_col_idx;
      next_col     = col_count_ff + 1'b1;
   end

   // Raster position and row window advance on each accepted beat.
   always_comb begin
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      window_in      = window_ff;
      s1_valid_in    = accept;
      s1_pix_in      = req_pixel_in;
      s1_row_in      = row_count_ff;
      s1_col_in      = col_count_ff;
      s1_last_row_in = at_last_row;
      s1_last_col_in = at_last_col;
      s1_win_in      = window_ff;
      if (accept) begin
         window_in = {window_ff[0], req_pixel_in};
         if (at_last_col) begin
            col_count_in = '0;
            row_count_in = at_last_row ? '0 : row_count_ff + 1'b1;
         end else begin
            col_count_in = next_col;
         end
      end
   end

   // Row store; reads are issued for the column of the next beat.
   bmf_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_COLS)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_data   (wr_data_in),
      .rd_addr_a (col_count_ff),
      .rd_data_a (rd_data_a),
      .rd_addr_b (next_col),
      .rd_data_b (rd_data_b)
   );

   // Forward the previous cycle's write when it hit an address that was just read.
   always_comb begin
      s1_col_right = s1_col_ff + 1'b1;
      entry_c = (wr_valid_ff && (wr_addr_ff == s1_col_ff))    ? wr_data_ff : rd_data_a;
      entry_r = (wr_valid_ff && (wr_addr_ff == s1_col_right)) ? wr_data_ff : rd_data_b;
      above_c  = entry_c[0];
      above2_c = entry_c[1];
      above_r  = entry_r[0];
   end

   // Store write-back: the row above moves to the older slot, the new pixel to the newer.
   always_comb begin
      wr_data_in     = {above_c, s1_pix_ff};
      wr_addr_in     = s1_col_ff;
      wr_valid_in    = s1_valid_ff;
      prev_center_in = s1_valid_ff ? above_c : prev_center_ff;
   end

   // Neighbor presence flags for the beat in the work stage.
   always_comb begin
      has_up    = s1_row_ff != '0;
      has_up2   = s1_row_ff > ROW_W'(1);
      has_left  = s1_col_ff != '0;
      has_left2 = s1_col_ff > COL_W'(1);
      has_right = !s1_last_col_ff;
      r1_en     = s1_valid_ff && has_up;
      r2_en     = s1_valid_ff && s1_last_row_ff && has_left;
      r3_en     = s1_valid_ff && s1_last_row_ff && s1_last_col_ff;
   end

   // Pixel one row up at this column, with the incoming pixel below it.
   always_comb begin
      present1 = 3'd1 + 3'(has_up2) + 3'(has_left) + 3'(has_right);
      whites1  = 3'(s1_pix_ff) + 3'(has_up2 & above2_c) + 3'(has_left & prev_center_ff)
               + 3'(has_right & above_r);
      res1.filtered_pixel = decide_pixel(above_c, present1, whites1);
      res1.out_row        = s1_row_ff - 1'b1;
      res1.out_col        = s1_col_ff;
      res1.end_of_image   = 1'b0;
   end

   // Last row: the pixel to the left, with the incoming pixel on its right.
   always_comb begin
      present2 = 3'd1 + 3'(has_up) + 3'(has_left2);
      whites2  = 3'(s1_pix_ff) + 3'(has_up & prev_center_ff) + 3'(has_left2 & s1_win_ff[1]);
      res2.filtered_pixel = decide_pixel(s1_win_ff[0], present2, whites2);
      res2.out_row        = s1_row_ff;
      res2.out_col        = s1_col_ff - 1'b1;
      res2.end_of_image   = 1'b0;
   end

   // Last row, last column: the incoming pixel itself closes the image.
   always_comb begin
      present3 = 3'(has_up) + 3'(has_left);
      whites3  = 3'(has_up & above_c) + 3'(has_left & s1_win_ff[0]);
      res3.filtered_pixel = decide_pixel(s1_pix_ff, present3, whites3);
      res3.out_row        = s1_row_ff;
      res3.out_col        = s1_col_ff;
      res3.end_of_image   = 1'b1;
   end

   // Pack the produced results in order into the queue's push slots.
   always_comb begin
      push_beats = {res1, res1, res1};
      push_count = '0;
      if (r1_en) begin
         push_beats[push_count] = res1;
         push_count = push_count + 1'b1;
      end
      if (r2_en) begin
         push_beats[push_count] = res2;
         push_count = push_count + 1'b1;
      end
      if (r3_en) begin
         push_beats[push_count] = res3;
         push_count = push_count + 1'b1;
      end
   end

   bmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_beats (push_beats),
      .pop        (pop),
      .head_beat  (head_beat),
      .level      (q_level)
   );

   // Take a new beat only if the queue can hold the work stage's results and a full burst.
   assign req_stall = ((QUEUE_AW+2)'(q_level) + (QUEUE_AW+2)'(push_count))
                      > (QUEUE_AW+2)'(QUEUE_DEPTH - MAX_BURST);

   // Result channel.
   assign rsp_valid          = q_level != '0;
   assign pop                = rsp_valid && !rsp_stall;
   assign rsp_filtered_pixel = head_beat.filtered_pixel;
   assign rsp_out_row        = head_beat.out_row;
   assign rsp_out_col        = head_beat.out_col;
   assign rsp_end_of_image   = head_beat.end_of_image;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff <= RESET_ROWS;
         image_cols_ff <= RESET_COLS;
         row_count_ff  <= '0;
         col_count_ff  <= '0;
         window_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
      end else begin
         image_rows_ff <= image_rows_in;
         image_cols_ff <= image_cols_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         window_ff     <= window_in;
         s1_valid_ff   <= s1_valid_in;
         wr_valid_ff   <= wr_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_pix_ff      <= s1_pix_in;
      s1_row_ff      <= s1_row_in;
      s1_col_ff      <= s1_col_in;
      s1_last_row_ff <= s1_last_row_in;
      s1_last_col_ff <= s1_last_col_in;
      s1_win_ff      <= s1_win_in;
      prev_center_ff <= prev_center_in;
      wr_addr_ff     <= wr_addr_in;
      wr_data_ff     <= wr_data_in;
   end

   // The queue never fills beyond its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // Above the last row a beat yields at most one result.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_last_row_ff) |-> (push_count <= 2'd1))
      else $error("more than one result above the last row");

   // An accepted beat reaches the work stage in the next cycle.
   a_stage_follow: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat lost before the work stage");

   // A stored write is always followed by its forwarding record.
   a_forward_track: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> (wr_valid_ff && (wr_addr_ff == $past(s1_col_ff))))
      else $error("forwarding record does not match the last write");

endmodule
